[rtl/core/mhpq_pkg.sv]
// shared types and codes for the max-heap priority queue
// no dependencies
package mhpq_pkg;

  localparam logic OpPush = 1'b0;
  localparam logic OpPop  = 1'b1;

  localparam int unsigned KeyWidth   = 32;
  localparam int unsigned CountWidth = 7;

  typedef enum logic [1:0] {
    ErrOk        = 2'd0,
    ErrUnderflow = 2'd1,
    ErrOverflow  = 2'd2
  } err_e;

  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctrl_t;

endpackage

[rtl/core/max_heap_priority_queue.sv]
// top level of the max-heap priority queue: chain of sorted key cells
// depends on mhpq_pkg and mhpq_cell
//
// Usage:
//   Requests arrive on the in channel (in_valid_i / in_ready_o) carrying an
//   opcode (0 push, 1 pop) and a signed 32-bit key. Every request yields one
//   result on the out channel (out_valid_o / out_ready_i): the largest key
//   held afterwards, its valid flag, the entry count and an error code
//   (0 ok, 1 pop on empty, 2 push on full; a failed request changes nothing).
//   Keys sit in a row of CAPACITY cells kept in descending order; on a push
//   each cell compares its key with the new one in parallel and the row
//   shifts right past the insertion point, on a pop the row shifts left.
//   The result is registered: it is loaded into the output register when the
//   request is accepted and is offered from the next cycle on. The queue takes
//   one request per cycle while the receiver keeps taking results.
//   The output register holds the result while the receiver stalls; a new
//   request is taken in the same cycle the held result is taken.
//   Reset clears the entry count and the output valid; cell contents are
//   left undefined and are never shown before being written.
module max_heap_priority_queue #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic                                   opcode_i,
  input  logic signed [mhpq_pkg::KeyWidth-1:0]   key_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [mhpq_pkg::KeyWidth-1:0]   top_key_o,
  output logic                                   top_valid_o,
  output logic [mhpq_pkg::CountWidth-1:0]        entry_count_o,
  output logic [1:0]                             error_code_o
);
  import mhpq_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]              count_q, count_d;
  logic                       out_valid_q;
  logic signed [KeyWidth-1:0] top_key_q, top_key_d;
  logic                       top_valid_q, top_valid_d;
  err_e                       err_q, err_d;

  logic                       accept, full, empty, do_push, do_pop;
  cell_ctrl_t                 ctrl;
  logic                       ge    [CAPACITY];
  logic signed [KeyWidth-1:0] cells [CAPACITY];

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign full       = (count_q == CW'(CAPACITY));
  assign empty      = (count_q == '0);
  assign do_push    = accept && (opcode_i == OpPush) && !full;
  assign do_pop     = accept && (opcode_i == OpPop) && !empty;
  assign ctrl.push  = do_push;
  assign ctrl.pop   = do_pop;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                       left_ge;
    logic signed [KeyWidth-1:0] left_key, right_key;
    if (i == 0) begin : g_first
      assign left_ge  = 1'b1;
      assign left_key = key_i;
    end else begin : g_inner
      assign left_ge  = ge[i-1];
      assign left_key = cells[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_key = cells[i];
    end else begin : g_body
      assign right_key = cells[i+1];
    end
    mhpq_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .occupied_i  (count_q > CW'(i)),
      .key_i       (key_i),
      .left_ge_i   (left_ge),
      .left_key_i  (left_key),
      .right_key_i (right_key),
      .ge_o        (ge[i]),
      .key_o       (cells[i])
    );
  end

  always_comb begin
    count_d     = count_q;
    top_key_d   = top_key_q;
    top_valid_d = top_valid_q;
    err_d       = err_q;
    if (accept) begin
      err_d = ErrOk;
      if (opcode_i == OpPush) begin
        if (full) begin
          err_d = ErrOverflow;
        end else begin
          count_d = count_q + CW'(1);
        end
      end else begin
        if (empty) begin
          err_d = ErrUnderflow;
        end else begin
          count_d = count_q - CW'(1);
        end
      end
      if (do_push) begin
        top_key_d = ge[0] ? cells[0] : key_i;
      end else if (do_pop) begin
        top_key_d = cells[1];
      end else begin
        top_key_d = cells[0];
      end
      top_valid_d = (count_d != '0);
      if (count_d == '0) begin
        top_key_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    top_key_q   <= top_key_d;
    top_valid_q <= top_valid_d;
    err_q       <= err_d;
  end

  assign out_valid_o   = out_valid_q;
  assign top_key_o     = top_key_q;
  assign top_valid_o   = top_valid_q;
  assign entry_count_o = CountWidth'(count_q);
  assign error_code_o  = err_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_top_sorted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q >= CW'(2)) |-> (cells[0] >= cells[1]))
    else $error("cell row out of order at the head");

  a_overflow_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && err_q == ErrOverflow) |-> full)
    else $error("overflow reported while not full");

  a_underflow_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && err_q == ErrUnderflow) |-> (empty && !top_valid_q))
    else $error("underflow reported while not empty");

endmodule

[rtl/core/mhpq_cell.sv]
// one storage cell of the sorted key chain
// depends on mhpq_pkg
module mhpq_cell (
  input  logic                                   clk_i,
  input  mhpq_pkg::cell_ctrl_t                   ctrl_i,
  input  logic                                   occupied_i,
  input  logic signed [mhpq_pkg::KeyWidth-1:0]   key_i,
  input  logic                                   left_ge_i,
  input  logic signed [mhpq_pkg::KeyWidth-1:0]   left_key_i,
  input  logic signed [mhpq_pkg::KeyWidth-1:0]   right_key_i,
  output logic                                   ge_o,
  output logic signed [mhpq_pkg::KeyWidth-1:0]   key_o
);
  import mhpq_pkg::*;

  logic signed [KeyWidth-1:0] key_q, key_d;

  assign ge_o  = occupied_i && (key_q >= key_i);
  assign key_o = key_q;

  always_comb begin
    key_d = key_q;
    if (ctrl_i.push) begin
      if (ge_o) begin
        key_d = key_q;
      end else if (left_ge_i) begin
        key_d = key_i;
      end else begin
        key_d = left_key_i;
      end
    end else if (ctrl_i.pop) begin
      key_d = right_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

endmodule

[tb/tb_max_heap_priority_queue.sv]
// testbench for the max-heap priority queue: a directed table of requests, then random traffic
// every result is checked against its typed row's status, else a shadow binary heap kept here
// depends on mhpq_pkg and the max_heap_priority_queue top level
module tb_max_heap_priority_queue;
  timeunit 1ns;
  timeprecision 1ps;

  import mhpq_pkg::*;

  localparam int unsigned Capacity    = 64;
  localparam int unsigned RandomItems = 1424;
  localparam int unsigned NumPhases   = 8;
  localparam int unsigned MaxReports  = 10;

  typedef struct packed {
    logic signed [KeyWidth-1:0] top_key;
    logic                       top_valid;
    logic [CountWidth-1:0]      entry_count;
    err_e                       error_code;
  } heap_status_t;

  typedef struct {
    logic                       op;
    logic signed [KeyWidth-1:0] key;
    int                         step;
    int                         reps;
    bit                         typed;
    heap_status_t               want;
  } stim_row_t;

  localparam heap_status_t NoStatus = '0;
  localparam logic signed [KeyWidth-1:0] KeyMax = 32'sh7fff_ffff;
  localparam logic signed [KeyWidth-1:0] KeyMin = 32'sh8000_0000;
  localparam logic signed [KeyWidth-1:0] ExtremeKeys [4] = '{KeyMax, KeyMin, 32'sd0, -32'sd1};

  // fill row ends on -2000 + 63 * 61
  stim_row_t directed_rows [20] = '{
    '{OpPop,  32'sd0,    0,  1, 1'b1, '{32'sd0,  1'b0, 7'd0,  ErrUnderflow}},
    '{OpPush, KeyMax,    0,  1, 1'b1, '{KeyMax,  1'b1, 7'd1,  ErrOk}},
    '{OpPush, KeyMin,    0,  1, 1'b1, '{KeyMax,  1'b1, 7'd2,  ErrOk}},
    '{OpPush, 32'sd0,    0,  1, 1'b0, NoStatus},
    '{OpPush, -32'sd1,   0,  1, 1'b0, NoStatus},
    '{OpPop,  32'sd0,    0,  1, 1'b0, NoStatus},
    '{OpPop,  -32'sd1,   0,  1, 1'b0, NoStatus},
    '{OpPop,  KeyMax,    0,  1, 1'b0, NoStatus},
    '{OpPop,  32'sd0,    0,  1, 1'b1, '{32'sd0,  1'b0, 7'd0,  ErrOk}},
    '{OpPop,  KeyMin,    0,  1, 1'b1, '{32'sd0,  1'b0, 7'd0,  ErrUnderflow}},
    '{OpPush, 32'sd42,   0,  5, 1'b0, NoStatus},
    '{OpPush, 32'sd41,   0,  1, 1'b0, NoStatus},
    '{OpPop,  32'sd0,    0,  6, 1'b0, NoStatus},
    '{OpPush, -32'sd2000, 61, 64, 1'b0, NoStatus},
    '{OpPush, 32'sd0,    0,  1, 1'b1, '{32'sd1843, 1'b1, 7'd64, ErrOverflow}},
    '{OpPush, KeyMax,    0,  1, 1'b1, '{32'sd1843, 1'b1, 7'd64, ErrOverflow}},
    '{OpPop,  32'sd0,    0, 64, 1'b0, NoStatus},
    '{OpPush, 32'sd1000, -7, 10, 1'b0, NoStatus},
    '{OpPop,  32'sd0,    0, 10, 1'b0, NoStatus},
    '{OpPop,  32'sd0,    0,  1, 1'b1, '{32'sd0,  1'b0, 7'd0,  ErrUnderflow}}
  };

  logic                       clk_i;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_ready_o;
  logic                       opcode_i;
  logic signed [KeyWidth-1:0] key_i;
  logic                       out_valid_o;
  logic                       out_ready_i;
  logic signed [KeyWidth-1:0] top_key_o;
  logic                       top_valid_o;
  logic [CountWidth-1:0]      entry_count_o;
  logic [1:0]                 error_code_o;

  logic signed [KeyWidth-1:0] shadow_heap [Capacity];
  int unsigned                shadow_fill;
  heap_status_t               status_expected_q [$];

  int unsigned max_gap;
  int unsigned max_stall;
  int unsigned n_push;
  int unsigned n_pop;
  int unsigned n_results;
  int unsigned n_underflow;
  int unsigned n_overflow;
  int unsigned n_mismatch;

  max_heap_priority_queue #(
    .CAPACITY(Capacity)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .opcode_i     (opcode_i),
    .key_i        (key_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .top_key_o    (top_key_o),
    .top_valid_o  (top_valid_o),
    .entry_count_o(entry_count_o),
    .error_code_o (error_code_o)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  function automatic heap_status_t apply_to_shadow_heap(logic op,
                                                        logic signed [KeyWidth-1:0] key);
    heap_status_t st;
    int unsigned pos, parent, lc, rc, best;
    logic signed [KeyWidth-1:0] tmp;
    st.error_code = ErrOk;
    if (op == OpPush) begin
      if (shadow_fill >= Capacity) begin
        st.error_code = ErrOverflow;
      end else begin
        pos = shadow_fill;
        shadow_heap[pos] = key;
        shadow_fill++;
        while (pos > 0) begin
          parent = (pos - 1) / 2;
          if (shadow_heap[pos] <= shadow_heap[parent]) break;
          tmp = shadow_heap[pos];
          shadow_heap[pos] = shadow_heap[parent];
          shadow_heap[parent] = tmp;
          pos = parent;
        end
      end
    end else if (shadow_fill == 0) begin
      st.error_code = ErrUnderflow;
    end else begin
      shadow_fill--;
      shadow_heap[0] = shadow_heap[shadow_fill];
      pos = 0;
      while (pos < shadow_fill) begin
        lc   = 2 * pos + 1;
        rc   = lc + 1;
        best = pos;
        if (lc < shadow_fill && shadow_heap[lc] > shadow_heap[best]) best = lc;
        if (rc < shadow_fill && shadow_heap[rc] > shadow_heap[best]) best = rc;
        if (best == pos) break;
        tmp = shadow_heap[pos];
        shadow_heap[pos] = shadow_heap[best];
        shadow_heap[best] = tmp;
        pos = best;
      end
    end
    st.top_valid   = (shadow_fill != 0);
    st.top_key     = st.top_valid ? shadow_heap[0] : '0;
    st.entry_count = CountWidth'(shadow_fill);
    return st;
  endfunction

  task automatic send_request(input logic op, input logic signed [KeyWidth-1:0] key,
                              input bit typed, input heap_status_t want);
    int unsigned gap;
    heap_status_t st;
    gap = $urandom_range(max_gap, 0);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    key_i      <= key;
    do @(posedge clk_i); while (!in_ready_o);
    st = apply_to_shadow_heap(op, key);
    status_expected_q = {status_expected_q, (typed ? want : st)};
    if (op == OpPush) n_push++;
    else n_pop++;
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (status_expected_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin : receiver
    int unsigned stall;
    wait (rst_ni === 1'b1);
    forever begin
      stall = $urandom_range(max_stall, 0);
      @(negedge clk_i);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin : result_check
    heap_status_t got;
    heap_status_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{top_key_o, top_valid_o, entry_count_o, err_e'(error_code_o)};
      n_results++;
      if (got.error_code == ErrUnderflow) n_underflow++;
      if (got.error_code == ErrOverflow) n_overflow++;
      if (status_expected_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= MaxReports) begin
          $display("result %0d arrived with no request outstanding:", n_results);
          $display("  top %0d valid %0b count %0d err %0d",
                   got.top_key, got.top_valid, got.entry_count, got.error_code);
        end
      end else begin
        want = status_expected_q.pop_front();
        if (got.top_key !== want.top_key || got.top_valid !== want.top_valid ||
            got.entry_count !== want.entry_count || got.error_code !== want.error_code) begin
          n_mismatch++;
          if (n_mismatch <= MaxReports) begin
            $display("result %0d: expected top %0d valid %0b count %0d err %0d",
                     n_results, want.top_key, want.top_valid, want.entry_count, want.error_code);
            $display("result %0d:      got top %0d valid %0b count %0d err %0d",
                     n_results, got.top_key, got.top_valid, got.entry_count, got.error_code);
          end
        end
      end
    end
  end

  initial begin : watchdog
    #2000000;
    $display("tb_max_heap_priority_queue failed");
    $finish;
  end

  initial begin : stimulus
    int unsigned phase, n, push_pct;
    logic op;
    logic signed [KeyWidth-1:0] key;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    opcode_i    = OpPush;
    key_i       = '0;
    out_ready_i = 1'b0;
    shadow_fill = 0;
    max_gap     = 15;
    max_stall   = 15;
    n_push      = 0;
    n_pop       = 0;
    n_results   = 0;
    n_underflow = 0;
    n_overflow  = 0;
    n_mismatch  = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[r]) begin
      for (int i = 0; i < directed_rows[r].reps; i++) begin
        send_request(directed_rows[r].op, directed_rows[r].key + i * directed_rows[r].step,
                     directed_rows[r].typed, directed_rows[r].want);
      end
    end
    drain_results();

    // phases alternate filling, churning near full and draining, each with its own idling
    for (phase = 0; phase < NumPhases; phase++) begin
      case (phase % 4)
        0: begin
          max_gap   = 0;
          max_stall = 0;
        end
        1: begin
          max_gap   = 15;
          max_stall = 15;
        end
        2: begin
          max_gap   = 0;
          max_stall = 15;
        end
        default: begin
          max_gap   = 15;
          max_stall = 0;
        end
      endcase
      push_pct = (phase % 3 == 0) ? 85 : (phase % 3 == 1) ? 50 : 20;
      for (n = 0; n < RandomItems / NumPhases; n++) begin
        op = ($urandom_range(99, 0) < push_pct) ? OpPush : OpPop;
        case ($urandom_range(3, 0))
          0:       key = $urandom_range(16, 0) - 8;
          1:       key = ExtremeKeys[$urandom_range(3, 0)];
          default: key = $urandom();
        endcase
        send_request(op, key, 1'b0, NoStatus);
      end
      drain_results();
    end

    repeat (8) @(posedge clk_i);
    $display("run covered %0d pushes and %0d pops, %0d results checked",
             n_push, n_pop, n_results);
    $display("%0d underflow and %0d overflow results seen, %0d mismatches",
             n_underflow, n_overflow, n_mismatch);
    if (n_mismatch == 0) begin
      $display("tb_max_heap_priority_queue passed");
    end else begin
      $display("tb_max_heap_priority_queue failed");
    end
    $finish;
  end

endmodule
